@@ hw/rtl/led_pattern_frame_generator_defines.svh @@
// Assertion helpers shared by the frame generator sources.
// Both sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef LED_PATTERN_FRAME_GENERATOR_DEFINES_SVH
`define LED_PATTERN_FRAME_GENERATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPFG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPFG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/lpfg_pkg.sv @@
package lpfg_pkg;

	localparam int NUM_LEDS_DEF = 16;

	localparam int PIX_W      = 6;
	localparam int COLOR_W    = 8;
	localparam int TIME_W     = 32;
	localparam int INTERVAL_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(20);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = CFG_IDX_W'(2);

	typedef enum logic [2:0] {
		PAT_IDLE,
		PAT_ALERT,
		PAT_HAPPY,
		PAT_ANGRY,
		PAT_AI,
		PAT_SLEEP,
		PAT_ERROR,
		PAT_OFF
	} pattern_t;

	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [PIX_W-1:0]   pix_t;

	// One rendered frame as handed from the frame control to the pixel stage
	typedef struct packed {
		pattern_t pattern;
		color_t   red;
		color_t   green;
		color_t   blue;
		pix_t     head;
	} frame_t;

	// Blink and flash timing, in frames
	localparam int ALERT_PERIOD = 10;
	localparam int ALERT_ON     = 5;
	localparam int ANGRY_PERIOD = 6;
	localparam int ANGRY_ON     = 3;
	localparam int ERROR_PERIOD = 40;
	localparam int ERROR_FLASH  = 4;

	localparam color_t FULL_ON     = 8'd255;
	localparam color_t ALERT_LOW   = 8'd40;
	localparam color_t ALERT_G_HI  = 8'd170;
	localparam color_t ALERT_G_LOW = 8'd26;
	localparam color_t ERROR_G     = 8'd153;

	// Chase shapes
	localparam int     HAPPY_TAIL = 4;
	localparam int     AI_TAIL    = 3;
	localparam color_t AI_PEAK    = 8'd200;
	localparam color_t AI_FLOOR   = 8'd10;
	localparam color_t AI_G0      = 8'd66;
	localparam color_t AI_G1      = 8'd33;
	localparam color_t AI_G2      = 8'd16;
	localparam color_t AI_G_FLOOR = 8'd3;

	// Breathe tables
	localparam int IDLE_ROM_DEPTH  = 160;
	localparam int SLEEP_ROM_DEPTH = 400;
	localparam int SLEEP_HALF      = SLEEP_ROM_DEPTH / 2;
	localparam int SLEEP_DIV       = 6;
	localparam int FRAC_BITS       = 30;
	localparam longint HALF_PI_Q   = 64'sd1686629713;

	typedef logic [COLOR_W-1:0] idle_rom_t [IDLE_ROM_DEPTH];
	typedef logic [COLOR_W-1:0] sleep_half_t [SLEEP_HALF];

	// Q30 sine over the first quadrant, Taylor series to the 17th power
	function automatic longint sine_q(longint theta);
		longint t2;
		longint term;
		longint sum;
		t2 = (theta * theta) >>> FRAC_BITS;
		term = theta;
		sum = theta;
		term = ((term * t2) >>> FRAC_BITS) / 6;
		sum = sum - term;
		term = ((term * t2) >>> FRAC_BITS) / 20;
		sum = sum + term;
		term = ((term * t2) >>> FRAC_BITS) / 42;
		sum = sum - term;
		term = ((term * t2) >>> FRAC_BITS) / 72;
		sum = sum + term;
		term = ((term * t2) >>> FRAC_BITS) / 110;
		sum = sum - term;
		term = ((term * t2) >>> FRAC_BITS) / 156;
		sum = sum + term;
		term = ((term * t2) >>> FRAC_BITS) / 210;
		sum = sum - term;
		term = ((term * t2) >>> FRAC_BITS) / 272;
		sum = sum + term;
		if (sum < 0) begin
			sum = 0;
		end
		return sum;
	endfunction

	// Entry k of the idle (short) or sleep (long) breathe table
	function automatic color_t breathe_entry(int k, bit long_table);
		int     n;
		int     q;
		int     r;
		longint theta;
		longint s;
		longint val;
		n = long_table ? SLEEP_ROM_DEPTH : IDLE_ROM_DEPTH;
		if (k == 0) begin
			return 8'd127;
		end
		if (4 * k == n) begin
			return 8'd254;
		end
		if (2 * k == n) begin
			return 8'd126;
		end
		if (4 * k == 3 * n) begin
			return 8'd0;
		end
		if (4 * k >= 3 * n) begin
			q = 3;
		end else if (4 * k >= 2 * n) begin
			q = 2;
		end else if (4 * k >= n) begin
			q = 1;
		end else begin
			q = 0;
		end
		r = 4 * k - q * n;
		if (q % 2 == 1) begin
			r = n - r;
		end
		if (long_table) begin
			theta = (HALF_PI_Q * longint'(r)) / SLEEP_ROM_DEPTH;
		end else begin
			theta = (HALF_PI_Q * longint'(r)) / IDLE_ROM_DEPTH;
		end
		s = sine_q(theta);
		if (q < 2) begin
			val = (longint'(127) <<< FRAC_BITS) + 127 * s;
		end else begin
			val = (longint'(127) <<< FRAC_BITS) - 127 * s;
		end
		if (val < 0) begin
			val = 0;
		end
		return color_t'(val >>> FRAC_BITS);
	endfunction

	function automatic idle_rom_t build_idle_rom();
		idle_rom_t rom;
		for (int k = 0; k < IDLE_ROM_DEPTH; k++) begin
			rom[k] = breathe_entry(k, 1'b0);
		end
		return rom;
	endfunction

	// Sleep entries come out already scaled down for the blue channel
	function automatic sleep_half_t build_sleep_half(int base);
		sleep_half_t rom;
		for (int k = 0; k < SLEEP_HALF; k++) begin
			rom[k] = color_t'(breathe_entry(base + k, 1'b1) / SLEEP_DIV);
		end
		return rom;
	endfunction

	localparam idle_rom_t   IDLE_ROM      = build_idle_rom();
	localparam sleep_half_t SLEEP_ROM_LO  = build_sleep_half(0);
	localparam sleep_half_t SLEEP_ROM_HI  = build_sleep_half(SLEEP_HALF);

endpackage

@@ hw/rtl/lpfg_frame_ctrl.sv @@
module lpfg_frame_ctrl
	import lpfg_pkg::*;
#(
	parameter int NUM_LEDS = NUM_LEDS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic                  frame_done,
	output logic                  frame_valid,
	output frame_t                frame
);

	localparam pix_t LAST_PIX = PIX_W'(NUM_LEDS - 1);

	logic                  enable_q;
	pattern_t              pattern_q;
	logic [INTERVAL_W-1:0] interval_q;

	logic [TIME_W-1:0] last_time_q;
	logic [TIME_W-1:0] frame_count_q;

	// Frame count reduced by each period, kept alongside the count itself
	logic [7:0] p160_q;
	logic [8:0] p400_q;
	logic [3:0] p10_q;
	logic [2:0] p6_q;
	logic [5:0] p40_q;
	pix_t       happy_head_q;
	logic       ai_odd_q;
	pix_t       ai_head_q;

	logic              frame_valid_s1;
	frame_t            frame_s1;

	logic [TIME_W-1:0] elapsed;
	logic              start;
	logic              wrap;
	frame_t            frame_next;
	color_t            v;
	logic              on;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			pattern_q  <= PAT_IDLE;
			interval_q <= INTERVAL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE:   enable_q   <= cfg_data[0];
				REG_PATTERN:  pattern_q  <= pattern_t'(cfg_data[2:0]);
				REG_INTERVAL: interval_q <= cfg_data[INTERVAL_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !frame_valid_s1 || frame_done;
	assign elapsed  = now_ms - last_time_q;
	assign start    = in_valid && in_ready && enable_q &&
		(elapsed >= TIME_W'(interval_q));
	assign wrap     = (frame_count_q == '1);

	always_comb begin
		frame_next         = '0;
		frame_next.pattern = pattern_q;
		v                  = '0;
		on                 = 1'b0;
		case (pattern_q)
			PAT_IDLE: begin
				v                = IDLE_ROM[p160_q];
				frame_next.red   = v;
				frame_next.green = v >> 1;
				frame_next.blue  = v >> 3;
			end
			PAT_ALERT: begin
				on               = (p10_q < 4'(ALERT_ON));
				frame_next.red   = on ? FULL_ON : ALERT_LOW;
				frame_next.green = on ? ALERT_G_HI : ALERT_G_LOW;
			end
			PAT_HAPPY: frame_next.head = happy_head_q;
			PAT_ANGRY: begin
				frame_next.red = (p6_q < 3'(ANGRY_ON)) ? FULL_ON : '0;
			end
			PAT_AI: frame_next.head = ai_head_q;
			PAT_SLEEP: begin
				if (p400_q < 9'(SLEEP_HALF)) begin
					frame_next.blue = SLEEP_ROM_LO[p400_q[7:0]];
				end else begin
					frame_next.blue = SLEEP_ROM_HI[8'(p400_q - 9'(SLEEP_HALF))];
				end
			end
			PAT_ERROR: begin
				// two short flashes at the head of each period
				on = (p40_q < 6'(ERROR_FLASH)) ||
					((p40_q >= 6'(2 * ERROR_FLASH)) && (p40_q < 6'(3 * ERROR_FLASH)));
				frame_next.red   = on ? FULL_ON : '0;
				frame_next.green = on ? ERROR_G : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q   <= '0;
			frame_count_q <= '0;
			p160_q        <= '0;
			p400_q        <= '0;
			p10_q         <= '0;
			p6_q          <= '0;
			p40_q         <= '0;
			happy_head_q  <= '0;
			ai_odd_q      <= 1'b0;
			ai_head_q     <= '0;
		end else if (start) begin
			last_time_q   <= now_ms;
			frame_count_q <= frame_count_q + 1'b1;
			// the count wrapping to zero restarts every phase
			p160_q <= (wrap || p160_q == 8'(IDLE_ROM_DEPTH - 1)) ? '0 : p160_q + 1'b1;
			p400_q <= (wrap || p400_q == 9'(SLEEP_ROM_DEPTH - 1)) ? '0 : p400_q + 1'b1;
			p10_q  <= (wrap || p10_q == 4'(ALERT_PERIOD - 1)) ? '0 : p10_q + 1'b1;
			p6_q   <= (wrap || p6_q == 3'(ANGRY_PERIOD - 1)) ? '0 : p6_q + 1'b1;
			p40_q  <= (wrap || p40_q == 6'(ERROR_PERIOD - 1)) ? '0 : p40_q + 1'b1;
			happy_head_q <= (wrap || happy_head_q == LAST_PIX) ? '0 : happy_head_q + 1'b1;
			ai_odd_q     <= wrap ? 1'b0 : !ai_odd_q;
			if (wrap) begin
				ai_head_q <= '0;
			end else if (ai_odd_q) begin
				ai_head_q <= (ai_head_q == LAST_PIX) ? '0 : ai_head_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (start) begin
			frame_valid_s1 <= 1'b1;
		end else if (frame_done) begin
			frame_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			frame_s1 <= frame_next;
		end
	end

	assign frame_valid = frame_valid_s1;
	assign frame       = frame_s1;

endmodule

@@ hw/rtl/lpfg_pixel_gen.sv @@
module lpfg_pixel_gen
	import lpfg_pkg::*;
#(
	parameter int NUM_LEDS = NUM_LEDS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   frame_valid,
	input  frame_t frame,
	output logic   frame_done,
	output logic   out_valid,
	input  logic   out_ready,
	output pix_t   pixel_index,
	output color_t red,
	output color_t green,
	output color_t blue,
	output logic   last_pixel
);

	localparam pix_t LAST_PIX = PIX_W'(NUM_LEDS - 1);

	pix_t   idx_q;
	logic   out_valid_q;
	pix_t   pixel_index_s2;
	color_t red_s2;
	color_t green_s2;
	color_t blue_s2;
	logic   last_s2;

	logic          advance;
	logic          last;
	logic [PIX_W:0] lag_wide;
	pix_t          lag;
	color_t        w;
	color_t        r_next;
	color_t        g_next;
	color_t        b_next;

	assign advance    = frame_valid && (!out_valid_q || out_ready);
	assign last       = (idx_q == LAST_PIX);
	assign frame_done = advance && last;

	// distance behind the chase head, modulo the strip length
	always_comb begin
		if (idx_q >= frame.head) begin
			lag_wide = (PIX_W + 1)'(idx_q) - (PIX_W + 1)'(frame.head);
		end else begin
			lag_wide = (PIX_W + 1)'(idx_q) + (PIX_W + 1)'(NUM_LEDS)
				- (PIX_W + 1)'(frame.head);
		end
		lag = lag_wide[PIX_W-1:0];
	end

	always_comb begin
		r_next = frame.red;
		g_next = frame.green;
		b_next = frame.blue;
		w      = '0;
		case (frame.pattern)
			PAT_HAPPY: begin
				w      = (lag < PIX_W'(HAPPY_TAIL)) ? (FULL_ON >> lag) : '0;
				g_next = w;
				b_next = w >> 2;
			end
			PAT_AI: begin
				w = (lag < PIX_W'(AI_TAIL)) ? (AI_PEAK >> lag) : AI_FLOOR;
				b_next = w;
				case (lag)
					PIX_W'(0): g_next = AI_G0;
					PIX_W'(1): g_next = AI_G1;
					PIX_W'(2): g_next = AI_G2;
					default:   g_next = AI_G_FLOOR;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q <= last ? '0 : idx_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pixel_index_s2 <= idx_q;
			red_s2         <= r_next;
			green_s2       <= g_next;
			blue_s2        <= b_next;
			last_s2        <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = pixel_index_s2;
	assign red         = red_s2;
	assign green       = green_s2;
	assign blue        = blue_s2;
	assign last_pixel  = last_s2;

endmodule

@@ hw/rtl/led_pattern_frame_generator.sv @@
// LED pattern frame generator.
// Input channel (in_valid/in_ready, now_ms): one millisecond timestamp per beat.
// When enabled and at least frame_interval_ms have passed since the last frame
// (wrapping difference), the timestamp starts a frame; otherwise it is dropped.
// Output channel (out_valid/out_ready): NUM_LEDS beats per frame, pixel 0 first,
// last_pixel set on pixel NUM_LEDS-1, colors chosen by pattern_select.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 enable,
// 1 pattern_select, 2 frame_interval_ms; other indexes are ignored. Always ready.
// Pixel 0 reaches the output through the frame register and then the output
// register. Throughput: one pixel beat per cycle, set by the single pixel
// stage, while the receiver is ready. The next timestamp is taken in the cycle
// the last pixel of a frame enters the output register, so frames stream back
// to back.
// A stalled receiver holds the output register; the pixel stage and the input
// channel wait behind it, nothing is lost.
// Reset clears enable, the frame counter and the last frame time, sets the
// interval to 20 ms and the pattern to idle breathe.
`include "led_pattern_frame_generator_defines.svh"

module led_pattern_frame_generator
	import lpfg_pkg::*;
#(
	parameter int NUM_LEDS = NUM_LEDS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TIME_W-1:0]     now_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      pixel_index,
	output logic [COLOR_W-1:0]    red,
	output logic [COLOR_W-1:0]    green,
	output logic [COLOR_W-1:0]    blue,
	output logic                  last_pixel
);

	logic   frame_valid;
	logic   frame_done;
	frame_t frame;

	lpfg_frame_ctrl #(
		.NUM_LEDS(NUM_LEDS)
	) u_frame_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.now_ms     (now_ms),
		.frame_done (frame_done),
		.frame_valid(frame_valid),
		.frame      (frame)
	);

	lpfg_pixel_gen #(
		.NUM_LEDS(NUM_LEDS)
	) u_pixel_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_valid(frame_valid),
		.frame      (frame),
		.frame_done (frame_done),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_index(pixel_index),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last_pixel (last_pixel)
	);

	`LPFG_ASSERT_SAME(a_last_index, out_valid && last_pixel, pixel_index == PIX_W'(NUM_LEDS - 1), "last_pixel flagged away from the final LED")
	`LPFG_ASSERT_NEXT(a_pixel_order, out_valid && out_ready && !last_pixel, out_valid && (pixel_index == PIX_W'($past(pixel_index) + 1'b1)), "pixels of a frame out of order")
	`LPFG_ASSERT_NEXT(a_frame_drains, frame_valid && !out_valid, out_valid, "pending frame produced no pixel")

endmodule
